[hw/rtl/pfc_pkg.sv]
package pfc_pkg;

  // Result buffer holds every result one item can cause
  localparam int unsigned MAX_RES   = 8;
  localparam int unsigned RES_IDX_W = $clog2(MAX_RES);
  localparam int unsigned RES_CNT_W = $clog2(MAX_RES + 1);

  localparam int unsigned QUEUE_DEPTH = 2;

  localparam int unsigned WIN_W  = 14;
  localparam int unsigned CORR_W = 17;
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = CORR_W;

  localparam logic [WIN_W-1:0]  WINDOW_MAX         = WIN_W'(15000);
  localparam logic [WIN_W-1:0]  WINDOW_DEFAULT     = WIN_W'(5000);
  localparam logic [CORR_W-1:0] CORR_RESET_DEFAULT = CORR_W'(120000);

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_NEG_FILTER_EN  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_POS_FILTER_EN  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_ABSENT_WINDOW  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_DISENG_WINDOW  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_ENGAGED_WINDOW = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_CORR_RESET     = 3'd5;

  // Sensor presence codes, ordered by priority
  localparam logic [1:0] PR_INVALID = 2'd0;
  localparam logic [1:0] PR_ABSENT  = 2'd1;
  localparam logic [1:0] PR_DISENG  = 2'd2;
  localparam logic [1:0] PR_ENGAGED = 2'd3;

  // Platform presence codes
  localparam logic [2:0] PP_ENGAGED      = 3'd3;
  localparam logic [2:0] PP_FACE_ENGAGED = 3'd4;

  // Platform enrollment codes
  localparam logic [2:0] PE_INVALID        = 3'd0;
  localparam logic [2:0] PE_ABSENT         = 3'd1;
  localparam logic [2:0] PE_DISENG         = 3'd2;
  localparam logic [2:0] PE_DISENG_FACEID  = 3'd3;
  localparam logic [2:0] PE_ENGAGED        = 3'd4;
  localparam logic [2:0] PE_ENGAGED_FACEID = 3'd5;
  localparam logic [2:0] PE_FACE_ENGAGED   = 3'd6;

  // Stored enrollment codes that carry a face id
  localparam logic [2:0] ENR_DISENG_FACEID = 3'd3;
  localparam logic [2:0] ENR_ENG_FACEID    = 3'd5;

  localparam logic KIND_PRESENCE    = 1'b0;
  localparam logic KIND_CORRELATION = 1'b1;

  typedef enum logic [1:0] {
    OP_PRESENCE = 2'd0,
    OP_ENROLL   = 2'd1,
    OP_INTERACT = 2'd2,
    OP_TICK     = 2'd3
  } op_e;

  typedef struct packed {
    op_e        op;
    logic [2:0] val;
  } item_t;

  typedef struct packed {
    logic       kind;
    logic [2:0] pres;
    logic [2:0] enr;
    logic       corr;
  } res_t;

  typedef struct packed {
    logic                 en;
    logic [RES_CNT_W-1:0] n;
  } load_t;

endpackage

[hw/rtl/pfc_front.sv]
module pfc_front #(
  parameter int unsigned QDepth = pfc_pkg::QUEUE_DEPTH
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_stall_o,
  input  logic [1:0]    action_i,
  input  logic [2:0]    report_value_i,
  output logic          item_valid_o,
  output pfc_pkg::item_t item_o,
  input  logic          item_take_i
);

  localparam int unsigned PtrW = (QDepth > 1) ? $clog2(QDepth) : 1;
  localparam int unsigned CntW = $clog2(QDepth + 1);

  pfc_pkg::item_t ent_q [QDepth];
  logic [PtrW-1:0] wr_q, wr_d, rd_q, rd_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  pfc_pkg::item_t cls;
  logic keep, full, push;

  // Classify: decode the action, fold interaction to one bit
  always_comb begin
    keep = 1'b1;
    cls.val = report_value_i;
    case (action_i)
      pfc_pkg::OP_PRESENCE: begin
        cls.op = pfc_pkg::OP_PRESENCE;
        // drop presence codes above engaged, they change nothing
        keep = (report_value_i <= {1'b0, pfc_pkg::PR_ENGAGED});
      end
      pfc_pkg::OP_ENROLL: cls.op = pfc_pkg::OP_ENROLL;
      pfc_pkg::OP_INTERACT: begin
        cls.op = pfc_pkg::OP_INTERACT;
        cls.val = {2'b00, |report_value_i};
      end
      default: cls.op = pfc_pkg::OP_TICK;
    endcase
  end

  assign full = (cnt_q == CntW'(QDepth));
  assign in_stall_o = full;
  assign push = in_valid_i && !full && keep;
  assign item_valid_o = (cnt_q != '0);
  assign item_o = ent_q[rd_q];

  always_comb begin
    wr_d = wr_q;
    rd_d = rd_q;
    cnt_d = cnt_q;
    if (push) begin
      wr_d = (wr_q == PtrW'(QDepth - 1)) ? '0 : wr_q + PtrW'(1);
    end
    if (item_take_i) begin
      rd_d = (rd_q == PtrW'(QDepth - 1)) ? '0 : rd_q + PtrW'(1);
    end
    if (push && !item_take_i) begin
      cnt_d = cnt_q + CntW'(1);
    end else if (!push && item_take_i) begin
      cnt_d = cnt_q - CntW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q <= '0;
      rd_q <= '0;
      cnt_q <= '0;
    end else begin
      wr_q <= wr_d;
      rd_q <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      ent_q[wr_q] <= cls;
    end
  end

endmodule

[hw/rtl/pfc_exec.sv]
module pfc_exec (
  input  logic                                      clk_i,
  input  logic                                      rst_ni,
  input  logic                                      item_valid_i,
  input  pfc_pkg::item_t                            item_i,
  output logic                                      item_take_o,
  input  logic                                      room_i,
  output pfc_pkg::load_t                            load_o,
  output pfc_pkg::res_t [pfc_pkg::MAX_RES-1:0]      res_o,
  input  logic                                      cfg_valid_i,
  input  logic [pfc_pkg::CFG_IDX_W-1:0]             cfg_index_i,
  input  logic [pfc_pkg::CFG_DATA_W-1:0]            cfg_data_i
);

  typedef struct packed {
    logic                        neg_en;
    logic                        pos_en;
    logic [pfc_pkg::WIN_W-1:0]   w_abs;
    logic [pfc_pkg::WIN_W-1:0]   w_dis;
    logic [pfc_pkg::WIN_W-1:0]   w_eng;
    logic [pfc_pkg::CORR_W-1:0]  corr_ms;
  } cfg_t;

  typedef struct packed {
    logic [1:0]                  committed;
    logic [1:0]                  pending;
    logic [1:0]                  queued;
    logic [2:0]                  enroll;
    logic                        inter;
    logic                        corr;
    logic [pfc_pkg::WIN_W-1:0]   filt_rem;
    logic                        filt_act;
    logic [pfc_pkg::CORR_W-1:0]  rst_rem;
    logic                        rst_act;
  } st_t;

  typedef struct packed {
    st_t                                   st;
    pfc_pkg::res_t [pfc_pkg::MAX_RES-1:0]  res;
    logic [pfc_pkg::RES_CNT_W-1:0]         n;
  } ctx_t;

  cfg_t cfg_q, cfg_d;
  st_t  st_q, st_d;
  ctx_t ctx;
  logic take;

  function automatic ctx_t emit(ctx_t c, logic kind, logic [2:0] p, logic [2:0] e,
                                logic corr);
    if (c.n < pfc_pkg::RES_CNT_W'(pfc_pkg::MAX_RES)) begin
      c.res[c.n[pfc_pkg::RES_IDX_W-1:0]] = '{kind: kind, pres: p, enr: e, corr: corr};
      c.n = c.n + pfc_pkg::RES_CNT_W'(1);
    end
    return c;
  endfunction

  function automatic ctx_t send_presence(ctx_t c, logic [1:0] s);
    logic [2:0] p;
    logic [2:0] e;
    e = pfc_pkg::PE_INVALID;
    if (s == pfc_pkg::PR_ENGAGED) begin
      p = pfc_pkg::PP_FACE_ENGAGED;
      e = (c.st.enroll == pfc_pkg::ENR_ENG_FACEID) ? pfc_pkg::PE_ENGAGED_FACEID
                                                   : pfc_pkg::PE_FACE_ENGAGED;
    end else if (s != pfc_pkg::PR_INVALID && c.st.inter) begin
      // interaction overrides to engaged
      p = pfc_pkg::PP_ENGAGED;
      e = (c.st.enroll == pfc_pkg::ENR_DISENG_FACEID) ? pfc_pkg::PE_ENGAGED_FACEID
                                                      : pfc_pkg::PE_ENGAGED;
    end else begin
      p = {1'b0, s};
      if (s == pfc_pkg::PR_ABSENT) begin
        e = pfc_pkg::PE_ABSENT;
      end else if (s == pfc_pkg::PR_DISENG) begin
        e = (c.st.enroll == pfc_pkg::ENR_DISENG_FACEID) ? pfc_pkg::PE_DISENG_FACEID
                                                        : pfc_pkg::PE_DISENG;
      end
    end
    return emit(c, pfc_pkg::KIND_PRESENCE, p, e, 1'b0);
  endfunction

  function automatic ctx_t send_correlation(ctx_t c);
    return emit(c, pfc_pkg::KIND_CORRELATION, 3'd0, 3'd0, c.st.corr);
  endfunction

  function automatic ctx_t eval_corr(ctx_t c, cfg_t cf, logic inter);
    logic corr;
    corr = 1'b1;
    if (c.st.committed == pfc_pkg::PR_ENGAGED) begin
      c.st.rst_act = 1'b0;
    end else if (inter) begin
      corr = 1'b0;
      c.st.rst_act = 1'b0;
      if (!c.st.inter) begin
        c.st.inter = 1'b1;
        c = send_presence(c, c.st.committed);
      end
    end else begin
      corr = c.st.corr;
      if (!c.st.corr && c.st.committed == pfc_pkg::PR_ABSENT) begin
        if (!c.st.rst_act) begin
          c.st.rst_rem = cf.corr_ms;
          c.st.rst_act = 1'b1;
        end
      end else if (c.st.committed == pfc_pkg::PR_DISENG) begin
        c.st.rst_act = 1'b0;
      end
      if (c.st.inter) begin
        c.st.inter = 1'b0;
        c = send_presence(c, c.st.committed);
      end
    end
    c.st.inter = inter;
    if (corr != c.st.corr) begin
      c.st.corr = corr;
      c = send_correlation(c);
    end
    return c;
  endfunction

  function automatic ctx_t send_events(ctx_t c, cfg_t cf);
    c = send_presence(c, c.st.committed);
    if (c.st.rst_act && c.st.committed != pfc_pkg::PR_ABSENT) begin
      c.st.rst_act = 1'b0;
    end
    return eval_corr(c, cf, c.st.inter);
  endfunction

  function automatic ctx_t stop_filter(ctx_t c);
    c.st.pending = pfc_pkg::PR_INVALID;
    c.st.queued = pfc_pkg::PR_INVALID;
    c.st.filt_act = 1'b0;
    return c;
  endfunction

  function automatic ctx_t commit(ctx_t c, cfg_t cf, logic [1:0] s);
    c.st.committed = s;
    c = stop_filter(c);
    return send_events(c, cf);
  endfunction

  function automatic ctx_t start_filter(ctx_t c, cfg_t cf, logic [1:0] s);
    logic [pfc_pkg::WIN_W-1:0] w;
    if (s == pfc_pkg::PR_ENGAGED) begin
      w = cf.w_eng;
    end else if (s == pfc_pkg::PR_DISENG) begin
      w = cf.w_dis;
    end else begin
      w = cf.w_abs;
    end
    if (w == '0) begin
      c = commit(c, cf, s);
    end else begin
      c.st.filt_rem = w;
      c.st.filt_act = 1'b1;
    end
    return c;
  endfunction

  function automatic ctx_t filter_report(ctx_t c, cfg_t cf, logic [1:0] s);
    if (!c.st.filt_act) begin
      c.st.pending = s;
      c = start_filter(c, cf, s);
    end else if (c.st.pending > s) begin
      c.st.queued = s;
    end else begin
      c.st.pending = s;
      c.st.queued = pfc_pkg::PR_INVALID;
    end
    return c;
  endfunction

  function automatic ctx_t sensor_report(ctx_t c, cfg_t cf, logic [1:0] s);
    if (s == c.st.committed) begin
      c = stop_filter(c);
    end else if (c.st.committed == pfc_pkg::PR_INVALID || s == pfc_pkg::PR_INVALID) begin
      c = commit(c, cf, s);
    end else if (s == c.st.pending) begin
      c.st.queued = pfc_pkg::PR_INVALID;
    end else if (cf.neg_en && s < c.st.committed) begin
      c = filter_report(c, cf, s);
    end else if (cf.pos_en && s > c.st.committed) begin
      c = filter_report(c, cf, s);
    end else begin
      c = commit(c, cf, s);
    end
    return c;
  endfunction

  function automatic ctx_t window_expired(ctx_t c, cfg_t cf);
    c.st.committed = c.st.pending;
    c = send_events(c, cf);
    if (c.st.queued != pfc_pkg::PR_INVALID) begin
      c.st.pending = c.st.queued;
      c.st.queued = pfc_pkg::PR_INVALID;
      c = start_filter(c, cf, c.st.pending);
    end else begin
      c.st.pending = pfc_pkg::PR_INVALID;
      c.st.filt_act = 1'b0;
    end
    return c;
  endfunction

  function automatic ctx_t tick(ctx_t c, cfg_t cf);
    // correlation countdown first, then the stability window
    if (c.st.rst_act) begin
      if (c.st.rst_rem <= pfc_pkg::CORR_W'(1)) begin
        c.st.rst_act = 1'b0;
        c.st.rst_rem = '0;
        c.st.corr = 1'b1;
        c = send_correlation(c);
        c = send_presence(c, c.st.committed);
      end else begin
        c.st.rst_rem = c.st.rst_rem - pfc_pkg::CORR_W'(1);
      end
    end
    if (c.st.filt_act) begin
      if (c.st.filt_rem <= pfc_pkg::WIN_W'(1)) begin
        c.st.filt_rem = '0;
        c = window_expired(c, cf);
      end else begin
        c.st.filt_rem = c.st.filt_rem - pfc_pkg::WIN_W'(1);
      end
    end
    return c;
  endfunction

  function automatic logic [pfc_pkg::WIN_W-1:0] sat_window(
      logic [pfc_pkg::CFG_DATA_W-1:0] v);
    logic [pfc_pkg::WIN_W-1:0] w;
    w = v[pfc_pkg::WIN_W-1:0];
    return (w > pfc_pkg::WINDOW_MAX) ? pfc_pkg::WINDOW_MAX : w;
  endfunction

  always_comb begin
    ctx.st = st_q;
    ctx.res = '0;
    ctx.n = '0;
    case (item_i.op)
      pfc_pkg::OP_PRESENCE: ctx = sensor_report(ctx, cfg_q, item_i.val[1:0]);
      pfc_pkg::OP_ENROLL:   ctx.st.enroll = item_i.val;
      pfc_pkg::OP_INTERACT: ctx = eval_corr(ctx, cfg_q, item_i.val[0]);
      pfc_pkg::OP_TICK:     ctx = tick(ctx, cfg_q);
      default: ;
    endcase
  end

  assign take = item_valid_i && room_i;
  assign item_take_o = take;
  assign load_o.en = take;
  assign load_o.n = ctx.n;
  assign res_o = ctx.res;
  assign st_d = take ? ctx.st : st_q;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_valid_i) begin
      case (cfg_index_i)
        pfc_pkg::REG_NEG_FILTER_EN:  cfg_d.neg_en = cfg_data_i[0];
        pfc_pkg::REG_POS_FILTER_EN:  cfg_d.pos_en = cfg_data_i[0];
        pfc_pkg::REG_ABSENT_WINDOW:  cfg_d.w_abs = sat_window(cfg_data_i);
        pfc_pkg::REG_DISENG_WINDOW:  cfg_d.w_dis = sat_window(cfg_data_i);
        pfc_pkg::REG_ENGAGED_WINDOW: cfg_d.w_eng = sat_window(cfg_data_i);
        pfc_pkg::REG_CORR_RESET:     cfg_d.corr_ms = cfg_data_i[pfc_pkg::CORR_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.neg_en <= 1'b0;
      cfg_q.pos_en <= 1'b0;
      cfg_q.w_abs <= pfc_pkg::WINDOW_DEFAULT;
      cfg_q.w_dis <= pfc_pkg::WINDOW_DEFAULT;
      cfg_q.w_eng <= pfc_pkg::WINDOW_DEFAULT;
      cfg_q.corr_ms <= pfc_pkg::CORR_RESET_DEFAULT;
      st_q.committed <= pfc_pkg::PR_INVALID;
      st_q.pending <= pfc_pkg::PR_INVALID;
      st_q.queued <= pfc_pkg::PR_INVALID;
      st_q.enroll <= 3'd0;
      st_q.inter <= 1'b0;
      st_q.corr <= 1'b1;
      st_q.filt_rem <= '0;
      st_q.filt_act <= 1'b0;
      st_q.rst_rem <= '0;
      st_q.rst_act <= 1'b0;
    end else begin
      cfg_q <= cfg_d;
      st_q <= st_d;
    end
  end

endmodule

[hw/rtl/pfc_outbuf.sv]
module pfc_outbuf (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  pfc_pkg::load_t                       load_i,
  input  pfc_pkg::res_t [pfc_pkg::MAX_RES-1:0] res_i,
  output logic                                 room_o,
  output logic                                 out_valid_o,
  input  logic                                 out_stall_i,
  output logic                                 event_kind_o,
  output logic [2:0]                           platform_presence_o,
  output logic [2:0]                           platform_enrollment_o,
  output logic                                 correlation_positive_o,
  output logic                                 last_result_o
);

  pfc_pkg::res_t [pfc_pkg::MAX_RES-1:0] res_q;
  logic [pfc_pkg::RES_CNT_W-1:0] rem_q, rem_d;
  logic [pfc_pkg::RES_IDX_W-1:0] rd_q, rd_d;
  pfc_pkg::res_t cur;
  logic take;

  assign cur = res_q[rd_q];
  assign out_valid_o = (rem_q != '0);
  assign take = out_valid_o && !out_stall_i;
  // accept a new batch once the last pending result leaves
  assign room_o = (rem_q == '0) || (rem_q == pfc_pkg::RES_CNT_W'(1) && take);

  assign event_kind_o = cur.kind;
  assign platform_presence_o = cur.pres;
  assign platform_enrollment_o = cur.enr;
  assign correlation_positive_o = cur.corr;
  assign last_result_o = (rem_q == pfc_pkg::RES_CNT_W'(1));

  always_comb begin
    rem_d = rem_q;
    rd_d = rd_q;
    if (load_i.en) begin
      rem_d = load_i.n;
      rd_d = '0;
    end else if (take) begin
      rem_d = rem_q - pfc_pkg::RES_CNT_W'(1);
      rd_d = rd_q + pfc_pkg::RES_IDX_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rem_q <= '0;
      rd_q <= '0;
    end else begin
      rem_q <= rem_d;
      rd_q <= rd_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i.en) begin
      res_q <= res_i;
    end
  end

endmodule

[hw/rtl/presence_filter_correlator.sv]
// Channel  Direction  Handshake                 Payload
// in       input      in_valid_i / in_stall_o   action_i, report_value_i
// out      output     out_valid_o / out_stall_i event_kind_o, platform_presence_o,
//                                               platform_enrollment_o,
//                                               correlation_positive_o, last_result_o
// cfg      input      cfg_valid_i / cfg_ready_o cfg_index_i, cfg_data_i
//
// An accepted transaction waits in a QueueDepth-entry queue, then executes at
// once, writing all of its results (up to eight) into the result buffer.
// Results leave one per cycle while out_stall_i is low; the executer takes the
// next item only once the result buffer is empty or its last result leaves.
// The first result is offered after the item passes the queue, then the result buffer.
// Reset is asynchronous, active low, and takes effect at once; no clearing pass.
module presence_filter_correlator #(
  parameter int unsigned QueueDepth = pfc_pkg::QUEUE_DEPTH
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              in_valid_i,
  output logic                              in_stall_o,
  input  logic [1:0]                        action_i,
  input  logic [2:0]                        report_value_i,
  output logic                              out_valid_o,
  input  logic                              out_stall_i,
  output logic                              event_kind_o,
  output logic [2:0]                        platform_presence_o,
  output logic [2:0]                        platform_enrollment_o,
  output logic                              correlation_positive_o,
  output logic                              last_result_o,
  input  logic                              cfg_valid_i,
  output logic                              cfg_ready_o,
  input  logic [pfc_pkg::CFG_IDX_W-1:0]     cfg_index_i,
  input  logic [pfc_pkg::CFG_DATA_W-1:0]    cfg_data_i
);

  logic item_valid, item_take, room;
  pfc_pkg::item_t item;
  pfc_pkg::load_t load;
  pfc_pkg::res_t [pfc_pkg::MAX_RES-1:0] res;

  assign cfg_ready_o = 1'b1;

  pfc_front #(
    .QDepth(QueueDepth)
  ) u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .action_i      (action_i),
    .report_value_i(report_value_i),
    .item_valid_o  (item_valid),
    .item_o        (item),
    .item_take_i   (item_take)
  );

  pfc_exec u_exec (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .item_valid_i(item_valid),
    .item_i      (item),
    .item_take_o (item_take),
    .room_i      (room),
    .load_o      (load),
    .res_o       (res),
    .cfg_valid_i (cfg_valid_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i)
  );

  pfc_outbuf u_outbuf (
    .clk_i                 (clk_i),
    .rst_ni                (rst_ni),
    .load_i                (load),
    .res_i                 (res),
    .room_o                (room),
    .out_valid_o           (out_valid_o),
    .out_stall_i           (out_stall_i),
    .event_kind_o          (event_kind_o),
    .platform_presence_o   (platform_presence_o),
    .platform_enrollment_o (platform_enrollment_o),
    .correlation_positive_o(correlation_positive_o),
    .last_result_o         (last_result_o)
  );

endmodule

[bench/pfc_event_checker.sv]
`timescale 1ns / 100ps

module pfc_event_checker
  import pfc_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  input  logic                  in_stall_i,
  input  logic [1:0]            action_i,
  input  logic [2:0]            report_value_i,
  input  logic                  out_valid_i,
  input  logic                  out_stall_i,
  input  logic                  event_kind_i,
  input  logic [2:0]            platform_presence_i,
  input  logic [2:0]            platform_enrollment_i,
  input  logic                  correlation_positive_i,
  input  logic                  last_result_i,
  input  logic                  cfg_valid_i,
  input  logic                  cfg_ready_i,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  output int unsigned           mismatch_count_o,
  output int unsigned           awaited_count_o,
  output int unsigned           events_checked_o,
  output int unsigned           corr_events_o
);

  localparam int unsigned REPORT_LIMIT = 10;

  typedef struct packed {
    res_t body;
    logic last;
  } platform_event_t;

  // Settings as seen through the configuration channel
  logic              neg_hold, pos_hold;
  logic [WIN_W-1:0]  absent_ms, diseng_ms, engaged_ms;
  logic [CORR_W-1:0] revert_len;

  // Presence tracking state
  logic [1:0]        cur_state, cand_state, next_cand;
  logic [2:0]        enroll_code;
  logic              user_active, corr_ok;
  logic [WIN_W-1:0]  hold_ms;
  logic              hold_running;
  logic [CORR_W-1:0] revert_ms;
  logic              revert_running;

  res_t              step_events[$];
  platform_event_t   awaited_events[$];
  int unsigned       mismatches, checked, corr_seen;

  function automatic void post_event(logic kind, logic [2:0] pres, logic [2:0] enr,
                                     logic corr);
    res_t ev;
    if (step_events.size() >= MAX_RES) return;
    ev.kind = kind;
    ev.pres = pres;
    ev.enr  = enr;
    ev.corr = corr;
    step_events.push_back(ev);
  endfunction

  function automatic void announce_presence(logic [1:0] s);
    logic [2:0] pres;
    logic [2:0] enr;
    if (s == PR_ENGAGED) begin
      pres = PP_FACE_ENGAGED;
      enr  = (enroll_code == ENR_ENG_FACEID) ? PE_ENGAGED_FACEID : PE_FACE_ENGAGED;
    end else if (s != PR_INVALID && user_active) begin
      // interaction overrides to engaged
      pres = PP_ENGAGED;
      enr  = (enroll_code == ENR_DISENG_FACEID) ? PE_ENGAGED_FACEID : PE_ENGAGED;
    end else begin
      pres = {1'b0, s};
      case (s)
        PR_ABSENT: enr = PE_ABSENT;
        PR_DISENG: enr = (enroll_code == ENR_DISENG_FACEID) ? PE_DISENG_FACEID : PE_DISENG;
        default:   enr = PE_INVALID;
      endcase
    end
    post_event(KIND_PRESENCE, pres, enr, 1'b0);
  endfunction

  function automatic void announce_correlation();
    post_event(KIND_CORRELATION, 3'd0, 3'd0, corr_ok);
  endfunction

  function automatic void update_correlation(logic inter);
    logic ok;
    ok = 1'b1;
    if (cur_state == PR_ENGAGED) begin
      revert_running = 1'b0;
    end else if (inter) begin
      ok             = 1'b0;
      revert_running = 1'b0;
      if (!user_active) begin
        user_active = 1'b1;
        announce_presence(cur_state);
      end
    end else begin
      ok = corr_ok;
      if (!corr_ok && cur_state == PR_ABSENT) begin
        // arm the revert countdown once, keep it running if already armed
        if (!revert_running) begin
          revert_ms      = revert_len;
          revert_running = 1'b1;
        end
      end else if (cur_state == PR_DISENG) begin
        revert_running = 1'b0;
      end
      if (user_active) begin
        user_active = 1'b0;
        announce_presence(cur_state);
      end
    end
    user_active = inter;
    if (ok != corr_ok) begin
      corr_ok = ok;
      announce_correlation();
    end
  endfunction

  function automatic void publish_state();
    announce_presence(cur_state);
    if (revert_running && cur_state != PR_ABSENT) revert_running = 1'b0;
    update_correlation(user_active);
  endfunction

  function automatic void cancel_hold();
    cand_state   = PR_INVALID;
    next_cand    = PR_INVALID;
    hold_running = 1'b0;
  endfunction

  function automatic void begin_hold(logic [1:0] s);
    logic [WIN_W-1:0] w;
    case (s)
      PR_ENGAGED: w = engaged_ms;
      PR_DISENG:  w = diseng_ms;
      default:    w = absent_ms;
    endcase
    if (w == '0) begin
      // zero window: commit right away
      cur_state = s;
      cancel_hold();
      publish_state();
    end else begin
      hold_ms      = w;
      hold_running = 1'b1;
    end
  endfunction

  function automatic void take_report(logic [1:0] s);
    if (!hold_running) begin
      cand_state = s;
      begin_hold(s);
    end else if (cand_state > s) begin
      next_cand = s;
    end else begin
      // replace the candidate without restarting the window
      cand_state = s;
      next_cand  = PR_INVALID;
    end
  endfunction

  function automatic void route_report(logic [2:0] v);
    logic [1:0] s;
    if (v[2]) return;  // drop codes above engaged
    s = v[1:0];
    if (s == cur_state) begin
      cancel_hold();
    end else if (cur_state == PR_INVALID || s == PR_INVALID) begin
      cur_state = s;
      cancel_hold();
      publish_state();
    end else if (s == cand_state) begin
      next_cand = PR_INVALID;
    end else if (neg_hold && s < cur_state) begin
      take_report(s);
    end else if (pos_hold && s > cur_state) begin
      take_report(s);
    end else begin
      cur_state = s;
      cancel_hold();
      publish_state();
    end
  endfunction

  function automatic void hold_done();
    cur_state = cand_state;
    publish_state();
    if (next_cand != PR_INVALID) begin
      cand_state = next_cand;
      next_cand  = PR_INVALID;
      begin_hold(cand_state);
    end else begin
      cand_state   = PR_INVALID;
      hold_running = 1'b0;
    end
  endfunction

  function automatic void ms_tick();
    // revert countdown goes first
    if (revert_running) begin
      if (revert_ms <= 1) begin
        revert_running = 1'b0;
        revert_ms      = '0;
        corr_ok        = 1'b1;
        announce_correlation();
        announce_presence(cur_state);
      end else begin
        revert_ms = revert_ms - 1'b1;
      end
    end
    if (hold_running) begin
      if (hold_ms <= 1) begin
        hold_ms = '0;
        hold_done();
      end else begin
        hold_ms = hold_ms - 1'b1;
      end
    end
  endfunction

  function automatic void predict_item(op_e op, logic [2:0] v);
    platform_event_t pe;
    step_events.delete();
    case (op)
      OP_PRESENCE: route_report(v);
      OP_ENROLL:   enroll_code = v;
      OP_INTERACT: update_correlation(v != 3'd0);
      default:     ms_tick();
    endcase
    foreach (step_events[i]) begin
      pe.body = step_events[i];
      pe.last = (i == step_events.size() - 1);
      awaited_events.push_back(pe);
    end
  endfunction

  function automatic void apply_config(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    logic [WIN_W-1:0] w;
    w = (data[WIN_W-1:0] > WINDOW_MAX) ? WINDOW_MAX : data[WIN_W-1:0];
    case (idx)
      REG_NEG_FILTER_EN:  neg_hold   = data[0];
      REG_POS_FILTER_EN:  pos_hold   = data[0];
      REG_ABSENT_WINDOW:  absent_ms  = w;
      REG_DISENG_WINDOW:  diseng_ms  = w;
      REG_ENGAGED_WINDOW: engaged_ms = w;
      REG_CORR_RESET:     revert_len = data[CORR_W-1:0];
      default: ;
    endcase
  endfunction

  function automatic void check_event(res_t got, logic got_last);
    platform_event_t want;
    if (got.kind == KIND_CORRELATION) corr_seen++;
    if (awaited_events.size() == 0) begin
      if (mismatches < REPORT_LIMIT)
        $display("%0t: unexpected event kind=%0d pres=%0d enr=%0d corr=%0d last=%0d",
                 $time, got.kind, got.pres, got.enr, got.corr, got_last);
      mismatches++;
      return;
    end
    want = awaited_events.pop_front();
    checked++;
    if (want.body.kind !== got.kind || want.body.pres !== got.pres ||
        want.body.enr !== got.enr || want.body.corr !== got.corr ||
        want.last !== got_last) begin
      if (mismatches < REPORT_LIMIT)
        $display("%0t: event mismatch, expected kind=%0d pres=%0d enr=%0d corr=%0d last=%0d, got kind=%0d pres=%0d enr=%0d corr=%0d last=%0d",
                 $time, want.body.kind, want.body.pres, want.body.enr, want.body.corr,
                 want.last, got.kind, got.pres, got.enr, got.corr, got_last);
      mismatches++;
    end
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      neg_hold       = 1'b0;
      pos_hold       = 1'b0;
      absent_ms      = WINDOW_DEFAULT;
      diseng_ms      = WINDOW_DEFAULT;
      engaged_ms     = WINDOW_DEFAULT;
      revert_len     = CORR_RESET_DEFAULT;
      cur_state      = PR_INVALID;
      cand_state     = PR_INVALID;
      next_cand      = PR_INVALID;
      enroll_code    = 3'd0;
      user_active    = 1'b0;
      corr_ok        = 1'b1;
      hold_ms        = '0;
      hold_running   = 1'b0;
      revert_ms      = '0;
      revert_running = 1'b0;
      awaited_events.delete();
      mismatches     = 0;
      checked        = 0;
      corr_seen      = 0;
    end else begin
      if (cfg_valid_i && cfg_ready_i) apply_config(cfg_index_i, cfg_data_i);
      if (out_valid_i && !out_stall_i)
        check_event('{kind: event_kind_i, pres: platform_presence_i,
                      enr: platform_enrollment_i, corr: correlation_positive_i},
                    last_result_i);
      if (in_valid_i && !in_stall_i) predict_item(op_e'(action_i), report_value_i);
    end
    mismatch_count_o <= mismatches;
    awaited_count_o  <= awaited_events.size();
    events_checked_o <= checked;
    corr_events_o    <= corr_seen;
  end

endmodule

[bench/tb_presence_filter_correlator.sv]
`timescale 1ns / 100ps

module tb_presence_filter_correlator;
  import pfc_pkg::*;

  localparam int unsigned CYCLE_LIMIT     = 400000;
  localparam int unsigned DRAIN_CYCLES    = 16;
  localparam int unsigned HOLD_OFF_CYCLES = 300;
  localparam int unsigned PHASE_ITEMS     = 90;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  in_valid = 1'b0;
  logic                  in_stall;
  logic [1:0]            action = 2'd0;
  logic [2:0]            report = 3'd0;
  logic                  out_valid;
  logic                  out_stall = 1'b0;
  logic                  event_kind;
  logic [2:0]            platform_presence;
  logic [2:0]            platform_enrollment;
  logic                  correlation_positive;
  logic                  last_result;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  int unsigned mismatch_count, awaited_count, events_checked, corr_events;
  int unsigned cycle_count = 0;
  int unsigned hold_off_asks = 0;
  int unsigned hold_offs_done = 0;
  int unsigned settings_used = 0;
  int unsigned n_reports = 0, n_enrolls = 0, n_interacts = 0, n_ticks = 0;
  logic        steady = 1'b0;

  presence_filter_correlator dut (
    .clk_i                  (clk),
    .rst_ni                 (rst_n),
    .in_valid_i             (in_valid),
    .in_stall_o             (in_stall),
    .action_i               (action),
    .report_value_i         (report),
    .out_valid_o            (out_valid),
    .out_stall_i            (out_stall),
    .event_kind_o           (event_kind),
    .platform_presence_o    (platform_presence),
    .platform_enrollment_o  (platform_enrollment),
    .correlation_positive_o (correlation_positive),
    .last_result_o          (last_result),
    .cfg_valid_i            (cfg_valid),
    .cfg_ready_o            (cfg_ready),
    .cfg_index_i            (cfg_index),
    .cfg_data_i             (cfg_data)
  );

  pfc_event_checker event_check (
    .clk_i                  (clk),
    .rst_ni                 (rst_n),
    .in_valid_i             (in_valid),
    .in_stall_i             (in_stall),
    .action_i               (action),
    .report_value_i         (report),
    .out_valid_i            (out_valid),
    .out_stall_i            (out_stall),
    .event_kind_i           (event_kind),
    .platform_presence_i    (platform_presence),
    .platform_enrollment_i  (platform_enrollment),
    .correlation_positive_i (correlation_positive),
    .last_result_i          (last_result),
    .cfg_valid_i            (cfg_valid),
    .cfg_ready_i            (cfg_ready),
    .cfg_index_i            (cfg_index),
    .cfg_data_i             (cfg_data),
    .mismatch_count_o       (mismatch_count),
    .awaited_count_o        (awaited_count),
    .events_checked_o       (events_checked),
    .corr_events_o          (corr_events)
  );

  initial begin
    forever #2 clk = ~clk;
  end

  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("presence_filter_correlator test failed");
    $finish;
  end

  // Event sink: random stalls, a quiet stretch, and one long hold-off on request
  initial begin
    forever begin
      @(posedge clk);
      if (hold_offs_done < hold_off_asks) begin
        out_stall <= 1'b1;
        repeat (HOLD_OFF_CYCLES) @(posedge clk);
        hold_offs_done++;
      end else if (steady) begin
        out_stall <= 1'b0;
      end else begin
        out_stall <= ($urandom_range(0, 99) < 30);
      end
    end
  end

  function automatic item_t mk(op_e op, logic [2:0] v);
    item_t it;
    it.op  = op;
    it.val = v;
    return it;
  endfunction

  function automatic item_t random_item();
    int unsigned pick;
    int unsigned sub;
    logic [2:0]  v;
    pick = $urandom_range(0, 99);
    sub  = $urandom_range(0, 99);
    if (pick < 45) return mk(OP_TICK, 3'($urandom_range(0, 7)));
    if (pick < 75) begin
      if (sub < 8)       v = 3'(PR_INVALID);
      else if (sub < 88) v = 3'($urandom_range(1, 3));
      else               v = 3'($urandom_range(4, 7));
      return mk(OP_PRESENCE, v);
    end
    if (pick < 90) begin
      v = (sub < 50) ? 3'd0 : 3'($urandom_range(1, 7));
      return mk(OP_INTERACT, v);
    end
    if (sub < 50) v = (sub < 25) ? ENR_DISENG_FACEID : ENR_ENG_FACEID;
    else          v = 3'($urandom_range(0, 7));
    return mk(OP_ENROLL, v);
  endfunction

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, int unsigned value);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= CFG_DATA_W'(value);
    do @(posedge clk); while (!cfg_ready);
  endtask

  task automatic configure(int unsigned neg, int unsigned pos, int unsigned absent,
                           int unsigned diseng, int unsigned engaged, int unsigned revert);
    write_reg(REG_NEG_FILTER_EN, neg);
    write_reg(REG_POS_FILTER_EN, pos);
    write_reg(REG_ABSENT_WINDOW, absent);
    write_reg(REG_DISENG_WINDOW, diseng);
    write_reg(REG_ENGAGED_WINDOW, engaged);
    write_reg(REG_CORR_RESET, revert);
    cfg_valid <= 1'b0;
    settings_used++;
  endtask

  task automatic send_item(item_t it);
    in_valid <= 1'b1;
    action   <= it.op;
    report   <= it.val;
    do @(posedge clk); while (in_stall);
    case (it.op)
      OP_PRESENCE: n_reports++;
      OP_ENROLL:   n_enrolls++;
      OP_INTERACT: n_interacts++;
      default:     n_ticks++;
    endcase
  endtask

  task automatic sender_gap();
    if (!steady && $urandom_range(0, 99) < 30) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 2)) @(posedge clk);
    end
  endtask

  // Wait for every expected event, then let items without events finish too
  task automatic settle();
    @(posedge clk);
    while (awaited_count != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic run_items(item_t list[$], int hold_at);
    foreach (list[i]) begin
      if (i == hold_at) hold_off_asks++;
      send_item(list[i]);
      if (i != list.size() - 1) sender_gap();
    end
    in_valid <= 1'b0;
    settle();
  endtask

  task automatic random_phase(int hold_at);
    item_t       list[$];
    item_t       it;
    int unsigned counted;
    counted = 0;
    while (counted < PHASE_ITEMS) begin
      it = random_item();
      list.push_back(it);
      if (!(it.op == OP_PRESENCE && it.val[2])) counted++;
    end
    run_items(list, hold_at);
  endtask

  initial begin
    item_t script[$];
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Reset settings: no filtering, long revert time
    script.push_back(mk(OP_PRESENCE, 3'd0));
    script.push_back(mk(OP_PRESENCE, 3'd7));
    script.push_back(mk(OP_PRESENCE, 3'd3));
    script.push_back(mk(OP_ENROLL, 3'd5));
    script.push_back(mk(OP_PRESENCE, 3'd3));
    script.push_back(mk(OP_INTERACT, 3'd1));
    script.push_back(mk(OP_INTERACT, 3'd0));
    script.push_back(mk(OP_PRESENCE, 3'd2));
    script.push_back(mk(OP_ENROLL, 3'd3));
    script.push_back(mk(OP_INTERACT, 3'd7));
    script.push_back(mk(OP_TICK, 3'd0));
    script.push_back(mk(OP_PRESENCE, 3'd0));
    run_items(script, -1);

    // Both directions filtered, zero disengaged window, zero revert time
    configure(1, 1, 2, 0, 3, 0);
    script.delete();
    script.push_back(mk(OP_PRESENCE, 3'd1));
    script.push_back(mk(OP_INTERACT, 3'd4));
    script.push_back(mk(OP_INTERACT, 3'd0));
    script.push_back(mk(OP_TICK, 3'd7));
    script.push_back(mk(OP_PRESENCE, 3'd3));
    script.push_back(mk(OP_PRESENCE, 3'd2));
    script.push_back(mk(OP_PRESENCE, 3'd3));
    script.push_back(mk(OP_PRESENCE, 3'd2));
    script.push_back(mk(OP_TICK, 3'd0));
    script.push_back(mk(OP_TICK, 3'd0));
    script.push_back(mk(OP_TICK, 3'd0));
    script.push_back(mk(OP_PRESENCE, 3'd1));
    script.push_back(mk(OP_PRESENCE, 3'd2));
    script.push_back(mk(OP_TICK, 3'd0));
    script.push_back(mk(OP_TICK, 3'd0));
    run_items(script, -1);

    configure(1, 1, $urandom_range(0, 8), $urandom_range(0, 8), $urandom_range(0, 8),
              $urandom_range(0, 12));
    random_phase(-1);

    steady = 1'b1;
    configure(1, 0, $urandom_range(1, 5), $urandom_range(1, 5), $urandom_range(1, 5),
              $urandom_range(1, 6));
    random_phase(-1);
    steady = 1'b0;

    configure(0, 1, $urandom_range(0, 4), $urandom_range(0, 4), $urandom_range(0, 4),
              $urandom_range(1, 20));
    random_phase(20);

    // Saturating window writes and the longest revert time
    configure(1, 1, 0, 17'h1FFFF, 15000, 17'h1FFFF);
    random_phase(-1);

    configure(0, 0, 16383, 15001, 1, $urandom_range(1, 4));
    random_phase(-1);

    $display("Sent %0d reports, %0d enrollments, %0d interactions and %0d ticks under %0d settings.",
             n_reports, n_enrolls, n_interacts, n_ticks, settings_used + 1);
    $display("Checked %0d events, %0d of them correlation changes, with %0d long hold-off(s).",
             events_checked, corr_events, hold_offs_done);
    if (mismatch_count == 0 && awaited_count == 0) begin
      $display("presence_filter_correlator test passed");
    end else begin
      $display("presence_filter_correlator test failed");
    end
    $finish;
  end

endmodule
